[design/pers_pkg.sv]
// Shared types and constants of the priority-evicting record store.
`timescale 1ns / 1ps
`default_nettype none

package pers_pkg;

  localparam int RECORDS_DEF       = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;

  localparam int SEQ_W  = 8;
  localparam int LVL_W  = 2;
  localparam int PFX_W  = 16;
  localparam int ID_W   = 8;
  localparam int CH_W   = 2;
  localparam int LEN_W  = 4;
  localparam int LENI_W = 8;
  localparam int DATA_W = 64;
  localparam int DATA_BYTES = DATA_W / 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Input item, last declared field (level) in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic [DATA_W-1:0] payload;
    logic [LENI_W-1:0] length;
    logic [CH_W-1:0]   chamber;
    logic [ID_W-1:0]   msg_id;
    logic [PFX_W-1:0]  prefix_code;
    logic [LVL_W-1:0]  level;
  } in_t;

  // Result item, last declared field (accepted) in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic              overflow_flag;
    logic [DATA_W-1:0] rec_payload;
    logic [LEN_W-1:0]  rec_length;
    logic [CH_W-1:0]   rec_chamber;
    logic [ID_W-1:0]   rec_id;
    logic [PFX_W-1:0]  rec_prefix;
    logic [LVL_W-1:0]  rec_level;
    logic [SEQ_W-1:0]  seq_num;
    logic              found;
    logic              evicted;
    logic              accepted;
  } res_t;

  // One stored record.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [LVL_W-1:0]  level;
    logic [PFX_W-1:0]  prefix;
    logic [ID_W-1:0]   ident;
    logic [CH_W-1:0]   chamber;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } rec_t;

  // Slot under test in the scan.
  typedef struct packed {
    logic             used;
    logic [LVL_W-1:0] level;
    logic [SEQ_W-1:0] seq;
  } cand_t;

  // Scan context for the age compare.
  typedef struct packed {
    logic             filt_on;
    logic [LVL_W-1:0] filt_lvl;
    logic             best_valid;
    logic [SEQ_W-1:0] best_seq;
    logic [SEQ_W-1:0] next_seq;
  } scan_ctl_t;

endpackage

`default_nettype wire

[design/pers_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/pers_age_cmp.sv]
// Shared eligibility and sequence-age compare used by the oldest-record scans.
`timescale 1ns / 1ps
`default_nettype none

module pers_age_cmp (
  input  wire pers_pkg::cand_t     cand,
  input  wire pers_pkg::scan_ctl_t ctl,
  output logic                     take
);

  logic eligible;
  logic older;

  always_comb begin
    eligible = cand.used && (!ctl.filt_on || (cand.level == ctl.filt_lvl));
    // Numbers at or above next_seq were issued before the wrap.
    if (cand.seq >= ctl.next_seq) begin
      older = (ctl.best_seq < ctl.next_seq) || (ctl.best_seq > cand.seq);
    end else begin
      older = (ctl.best_seq < ctl.next_seq) && (ctl.best_seq > cand.seq);
    end
    take = eligible && (!ctl.best_valid || older);
  end

endmodule

`default_nettype wire

[design/priority_evicting_record_store_core.sv]
// Top level of the priority-evicting record store: sequencer, slot table and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake           Contents
// s_*       in   s_tvalid/s_tready   command in tuser, new record fields in tdata
// m_*       out  m_tvalid/m_tready   status and returned record in tdata
//
// A write scans the table for a free slot; when the table is full and the new record's
// level is not below the lowest stored level, it scans again for the oldest record of
// that level and evicts it, else it is dropped. A read scans once for the oldest record.
// The next transfer can be taken in the cycle after the result is loaded. Each scan
// reads one slot per step through the single RAM read port; the eviction and read
// scans check each slot with the shared age compare.
// Reset (synchronous, active high) frees every slot and clears the sequence
// counter and overflow flag at once. s_tready is high only between items; a
// finished result waits in the output register while the next item is taken,
// and a stalled m_tready holds only the finishing step.

module priority_evicting_record_store_core #(
  parameter int RECORDS       = pers_pkg::RECORDS_DEF,
  parameter int PAYLOAD_BYTES = pers_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // level, prefix_code, msg_id, chamber, length, payload, zero fill
  input  wire logic [$bits(pers_pkg::in_t)-1:0]  s_tdata,
  // command
  input  wire logic [0:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // accepted, evicted, found, seq_num, rec_level, rec_prefix, rec_id,
  // rec_chamber, rec_length, rec_payload, overflow_flag, zero fill
  output logic [$bits(pers_pkg::res_t)-1:0]      m_tdata
);

  localparam int IDX_W = $clog2(RECORDS);
  localparam int CNT_W = $clog2(RECORDS + 1);
  localparam int REC_W = $bits(pers_pkg::rec_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_FREE,
    ST_SCAN_OLD,
    ST_COMMIT,
    ST_DONE
  } state_t;

  state_t                         st;
  logic                           cmd;
  pers_pkg::in_t                  in_q;
  logic [CNT_W-1:0]               cnt;
  logic                           chk;
  logic [IDX_W-1:0]               chk_idx;
  logic                           chk_used;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;
  logic [pers_pkg::LVL_W-1:0]     min_lvl;
  logic                           filt_on;
  logic [pers_pkg::LVL_W-1:0]     filt_lvl;
  logic                           best_valid;
  logic [IDX_W-1:0]               best_idx;
  pers_pkg::rec_t                 best_rec;
  logic [IDX_W-1:0]               tgt_idx;
  logic                           evict_q;
  logic [pers_pkg::SEQ_W-1:0]     next_seq;
  logic                           ovf;
  logic [RECORDS-1:0]             used;
  pers_pkg::res_t                 res;
  pers_pkg::res_t                 m_res;

  logic [IDX_W-1:0]               raddr;
  logic [REC_W-1:0]               rdata;
  pers_pkg::rec_t                 rd_rec;
  pers_pkg::rec_t                 new_rec;
  logic [pers_pkg::LEN_W-1:0]     len_sat;
  logic [pers_pkg::DATA_W-1:0]    keep_mask;
  pers_pkg::cand_t                cand;
  pers_pkg::scan_ctl_t            ctl;
  logic                           take;
  logic                           scan_done;
  pers_pkg::res_t                 wr_res;
  pers_pkg::res_t                 rej_res;
  pers_pkg::res_t                 rd_res;

  assign s_tready = (st == ST_IDLE);
  assign m_tdata  = m_res;
  assign raddr    = cnt[IDX_W-1:0];
  assign rd_rec   = pers_pkg::rec_t'(rdata);
  assign scan_done = (cnt == CNT_W'(RECORDS)) && !chk;

  // Slot table: one record per slot, read once per scan step.
  pers_ram #(
    .WIDTH (REC_W),
    .DEPTH (RECORDS)
  ) u_table (
    .clk   (clk),
    .we    (st == ST_COMMIT),
    .waddr (tgt_idx),
    .wdata (REC_W'(new_rec)),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cand.used  = chk_used;
    cand.level = rd_rec.level;
    cand.seq   = rd_rec.seq;
    ctl.filt_on    = filt_on;
    ctl.filt_lvl   = filt_lvl;
    ctl.best_valid = best_valid;
    ctl.best_seq   = best_rec.seq;
    ctl.next_seq   = next_seq;
  end

  pers_age_cmp u_cmp (
    .cand (cand),
    .ctl  (ctl),
    .take (take)
  );

  // Saturate the length and zero the payload bytes beyond it.
  always_comb begin
    if (in_q.length > pers_pkg::LENI_W'(PAYLOAD_BYTES)) begin
      len_sat = pers_pkg::LEN_W'(PAYLOAD_BYTES);
    end else begin
      len_sat = in_q.length[pers_pkg::LEN_W-1:0];
    end
    for (int b = 0; b < pers_pkg::DATA_BYTES; b++) begin
      keep_mask[8*b +: 8] = (pers_pkg::LEN_W'(b) < len_sat) ? 8'hFF : 8'h00;
    end
    new_rec.seq     = next_seq;
    new_rec.level   = in_q.level;
    new_rec.prefix  = in_q.prefix_code;
    new_rec.ident   = in_q.msg_id;
    new_rec.chamber = in_q.chamber;
    new_rec.len     = len_sat;
    new_rec.data    = in_q.payload & keep_mask;
  end

  // Result words for each way an item can finish.
  always_comb begin
    wr_res               = '0;
    wr_res.accepted      = 1'b1;
    wr_res.evicted       = evict_q;
    wr_res.overflow_flag = ovf;
    rej_res               = '0;
    rej_res.overflow_flag = 1'b1;
    rd_res               = '0;
    rd_res.overflow_flag = ovf;
    if (best_valid) begin
      rd_res.found       = 1'b1;
      rd_res.seq_num     = best_rec.seq;
      rd_res.rec_level   = best_rec.level;
      rd_res.rec_prefix  = best_rec.prefix;
      rd_res.rec_id      = best_rec.ident;
      rd_res.rec_chamber = best_rec.chamber;
      rd_res.rec_length  = best_rec.len;
      rd_res.rec_payload = best_rec.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      cnt        <= '0;
      chk        <= 1'b0;
      free_found <= 1'b0;
      filt_on    <= 1'b0;
      best_valid <= 1'b0;
      next_seq   <= '0;
      ovf        <= 1'b0;
      used       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // Drop the result once the sink has taken it, unless a new one loads now.
      if (m_tvalid && m_tready && (st != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_q       <= pers_pkg::in_t'(s_tdata);
            cmd        <= s_tuser[0];
            cnt        <= '0;
            chk        <= 1'b0;
            free_found <= 1'b0;
            min_lvl    <= '1;
            filt_on    <= 1'b0;
            best_valid <= 1'b0;
            st <= (s_tuser[0] == pers_pkg::CMD_WRITE) ? ST_SCAN_FREE : ST_SCAN_OLD;
          end
        end

        ST_SCAN_FREE, ST_SCAN_OLD: begin
          // Issue one table read per cycle; its data is checked in the next cycle.
          if (cnt < CNT_W'(RECORDS)) begin
            cnt      <= cnt + 1'b1;
            chk      <= 1'b1;
            chk_idx  <= raddr;
            chk_used <= used[raddr];
          end else begin
            chk <= 1'b0;
          end

          if (st == ST_SCAN_FREE) begin
            if (chk) begin
              if (!chk_used && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
              if (chk_used && (rd_rec.level < min_lvl)) begin
                min_lvl <= rd_rec.level;
              end
            end
            if (scan_done) begin
              if (free_found) begin
                tgt_idx <= free_idx;
                evict_q <= 1'b0;
                st      <= ST_COMMIT;
              end else begin
                ovf <= 1'b1;
                if (min_lvl <= in_q.level) begin
                  // Full: look for the oldest record of the lowest level.
                  filt_on    <= 1'b1;
                  filt_lvl   <= min_lvl;
                  best_valid <= 1'b0;
                  cnt        <= '0;
                  st         <= ST_SCAN_OLD;
                end else begin
                  res <= rej_res;
                  st  <= ST_DONE;
                end
              end
            end
          end else begin
            if (chk && take) begin
              best_valid <= 1'b1;
              best_idx   <= chk_idx;
              best_rec   <= rd_rec;
            end
            if (scan_done) begin
              if (cmd == pers_pkg::CMD_WRITE) begin
                tgt_idx <= best_idx;
                evict_q <= 1'b1;
                st      <= ST_COMMIT;
              end else begin
                res <= rd_res;
                if (best_valid) begin
                  used[best_idx] <= 1'b0;
                end
                ovf <= 1'b0;
                st  <= ST_DONE;
              end
            end
          end
        end

        ST_COMMIT: begin
          // The table write happens in this cycle through the RAM port.
          used[tgt_idx] <= 1'b1;
          next_seq      <= next_seq + 1'b1;
          res           <= wr_res;
          st            <= ST_DONE;
        end

        ST_DONE: begin
          // Hold until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_res    <= res;
            m_tvalid <= 1'b1;
            st       <= ST_IDLE;
          end
        end

        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/pers_chk.sv]
// Port-level checker for the record store and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pers_chk (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [$bits(pers_pkg::res_t)-1:0]  m_tdata
);

  pers_pkg::res_t r;
  assign r = pers_pkg::res_t'(m_tdata);

  // One item at a time: no transfer right after one was taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // A write result never carries a record, a read never stores one.
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(r.accepted && r.found) && (r.found || (r.seq_num == '0 &&
      r.rec_payload == '0 && r.rec_length == '0)))
    else $error("result mixes write and read fields");

  a_evict_flags: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r.evicted) |-> (r.accepted && r.overflow_flag))
    else $error("eviction without store or overflow");

endmodule

bind priority_evicting_record_store_core pers_chk u_pers_chk (.*);

`default_nettype wire
